[design/cobc_pkg.sv]
// Shared types, constants and tables for the circle versus oriented box test.
`default_nettype none

package cobc_pkg;

    localparam int CORDIC_STEPS = 14;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
    localparam int CX_W         = 34;
    localparam int CZ_W         = 22;
    localparam int CORDIC_GAIN  = 652032874;
    localparam int SQRT_LAT     = 30;
    localparam int SQRT_IN_W    = 2 * SQRT_LAT;
    localparam int DIV_BITS     = 15;
    localparam int DIV_LAT      = DIV_BITS + 1;
    localparam int PIPE_LAT     = CORDIC_LAT + SQRT_LAT + DIV_LAT + 7;
    localparam int NORM_ONE     = 16384;

    typedef struct packed {
        logic signed [31:0] circle_x;
        logic signed [31:0] circle_y;
        logic        [23:0] circle_radius;
        logic signed [31:0] box_x;
        logic signed [31:0] box_y;
        logic        [15:0] box_angle;
        logic        [23:0] box_width;
        logic        [23:0] box_height;
        logic               box_first;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic        [25:0] penetration;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [31:0] contact_x;
        logic signed [31:0] contact_y;
    } t_out;

    // arctangent table, units of 2^-22 turn
    function automatic logic signed [CZ_W-1:0] cordic_atan(input int i);
        logic signed [CZ_W-1:0] v;
        case (i)
            0:       v = 22'sd524288;
            1:       v = 22'sd309505;
            2:       v = 22'sd163534;
            3:       v = 22'sd83012;
            4:       v = 22'sd41667;
            5:       v = 22'sd20854;
            6:       v = 22'sd10430;
            7:       v = 22'sd5215;
            8:       v = 22'sd2608;
            9:       v = 22'sd1304;
            10:      v = 22'sd652;
            11:      v = 22'sd326;
            12:      v = 22'sd164;
            13:      v = 22'sd82;
            default: v = 22'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[design/cobc_cordic.sv]
// Pipelined CORDIC giving cos and sin of a binary angle in Q2.14.
`default_nettype none

module cobc_cordic import cobc_pkg::*; (
    input  wire                i_clk,
    input  wire                i_en,
    input  wire         [15:0] i_angle,
    output logic signed [15:0] o_cos,
    output logic signed [15:0] o_sin
);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic signed [CX_W-1:0] r_x [CORDIC_STEPS];
    logic signed [CX_W-1:0] r_y [CORDIC_STEPS];
    logic signed [CZ_W-1:0] r_z [CORDIC_STEPS];
    logic        [1:0]      r_q [CORDIC_STEPS];
    logic signed [CX_W-1:0] s_x [CORDIC_STEPS];
    logic signed [CX_W-1:0] s_y [CORDIC_STEPS];
    logic signed [CZ_W-1:0] s_z [CORDIC_STEPS];
    logic        [1:0]      s_q [CORDIC_STEPS];
    logic signed [CX_W-1:0] n_x [CORDIC_STEPS];
    logic signed [CX_W-1:0] n_y [CORDIC_STEPS];
    logic signed [CZ_W-1:0] n_z [CORDIC_STEPS];
    logic signed [17:0]     cr, sr;
    logic signed [15:0]     cc, sc;
    logic signed [15:0]     n_cos, n_sin;

    always_comb begin
        s_x[0] = CX_W'(CORDIC_GAIN);
        s_y[0] = '0;
        s_z[0] = CZ_W'({i_angle[13:0], 6'b0});
        s_q[0] = i_angle[15:14];
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            s_x[i] = r_x[i-1];
            s_y[i] = r_y[i-1];
            s_z[i] = r_z[i-1];
            s_q[i] = r_q[i-1];
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (s_z[i] >= 0) begin
                n_x[i] = s_x[i] - (s_y[i] >>> i);
                n_y[i] = s_y[i] + (s_x[i] >>> i);
                n_z[i] = s_z[i] - cordic_atan(i);
            end else begin
                n_x[i] = s_x[i] + (s_y[i] >>> i);
                n_y[i] = s_y[i] - (s_x[i] >>> i);
                n_z[i] = s_z[i] + cordic_atan(i);
            end
        end
    end

    always_comb begin
        cr = 18'((r_x[CORDIC_STEPS-1] + CX_W'(32768)) >>> 16);
        sr = 18'((r_y[CORDIC_STEPS-1] + CX_W'(32768)) >>> 16);
        if (cr > 18'sd16384) begin
            cc = 16'(NORM_ONE);
        end else if (cr < -18'sd16384) begin
            cc = -16'(NORM_ONE);
        end else begin
            cc = 16'(cr);
        end
        if (sr > 18'sd16384) begin
            sc = 16'(NORM_ONE);
        end else if (sr < -18'sd16384) begin
            sc = -16'(NORM_ONE);
        end else begin
            sc = 16'(sr);
        end
        case (r_q[CORDIC_STEPS-1])
            QUAD_0: begin
                n_cos = cc;
                n_sin = sc;
            end
            QUAD_1: begin
                n_cos = -sc;
                n_sin = cc;
            end
            QUAD_2: begin
                n_cos = -cc;
                n_sin = -sc;
            end
            default: begin
                n_cos = sc;
                n_sin = -cc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
                r_z[i] <= n_z[i];
                r_q[i] <= s_q[i];
            end
            o_cos <= n_cos;
            o_sin <= n_sin;
        end
    end

endmodule

`default_nettype wire

[design/cobc_isqrt.sv]
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module cobc_isqrt import cobc_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  wire  [SQRT_IN_W-1:0] i_rad,
    output logic [SQRT_LAT-1:0]  o_root
);

    logic [SQRT_LAT+2:0]  r_rem  [SQRT_LAT];
    logic [SQRT_LAT-1:0]  r_root [SQRT_LAT];
    logic [SQRT_IN_W-1:0] r_rad  [SQRT_LAT];
    logic [SQRT_LAT+2:0]  s_rem  [SQRT_LAT];
    logic [SQRT_LAT-1:0]  s_root [SQRT_LAT];
    logic [SQRT_IN_W-1:0] s_rad  [SQRT_LAT];
    logic [SQRT_LAT+2:0]  n_rem  [SQRT_LAT];
    logic [SQRT_LAT-1:0]  n_root [SQRT_LAT];
    logic [SQRT_LAT+2:0]  t_v    [SQRT_LAT];
    logic [SQRT_LAT+2:0]  trial  [SQRT_LAT];

    always_comb begin
        s_rem[0]  = '0;
        s_root[0] = '0;
        s_rad[0]  = i_rad;
        for (int i = 1; i < SQRT_LAT; i++) begin
            s_rem[i]  = r_rem[i-1];
            s_root[i] = r_root[i-1];
            s_rad[i]  = r_rad[i-1];
        end
        for (int i = 0; i < SQRT_LAT; i++) begin
            t_v[i]   = {s_rem[i][SQRT_LAT:0], s_rad[i][SQRT_IN_W-1 -: 2]};
            trial[i] = {1'b0, s_root[i], 2'b01};
            if (t_v[i] >= trial[i]) begin
                n_rem[i]  = t_v[i] - trial[i];
                n_root[i] = {s_root[i][SQRT_LAT-2:0], 1'b1};
            end else begin
                n_rem[i]  = t_v[i];
                n_root[i] = {s_root[i][SQRT_LAT-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < SQRT_LAT; i++) begin
                r_rem[i]  <= n_rem[i];
                r_root[i] <= n_root[i];
                r_rad[i]  <= {s_rad[i][SQRT_IN_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQRT_LAT-1];

endmodule

`default_nettype wire

[design/circle_vs_oriented_box_collision.sv]
// Top level: circle versus rotated box contact test, fully pipelined.
//
//  channel | valid   | stall   | word
//  input   | i_valid | o_stall | i_data (t_in)
//  output  | o_valid | i_stall | o_data (t_out)
//
// One word per cycle in and out while the output is not stalled; the path runs through the 15-stage
// CORDIC, the 30-stage square root and the 16-stage divider in series.
// Synchronous active-low reset clears only the stage valid bits.
// A stall on a valid output word freezes every stage; o_stall then holds the input.
`default_nettype none

module circle_vs_oriented_box_collision import cobc_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_stall,
    input  t_in   i_data,
    output logic  o_valid,
    input  wire   i_stall,
    output t_out  o_data
);

    localparam logic [1:0] FACE_L = 2'd0;
    localparam logic [1:0] FACE_R = 2'd1;
    localparam logic [1:0] FACE_B = 2'd2;
    localparam logic [1:0] FACE_T = 2'd3;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic        [23:0] rad;
        logic        [23:0] w;
        logic        [23:0] h;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic               bf;
    } t_sa;

    typedef struct packed {
        logic signed [48:0] pxc;
        logic signed [48:0] pys;
        logic signed [48:0] pyc;
        logic signed [48:0] pxs;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic        [23:0] rad;
        logic        [23:0] w;
        logic        [23:0] h;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic               bf;
    } t_sm;

    typedef struct packed {
        logic signed [34:0] lx;
        logic signed [34:0] ly;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic        [23:0] rad;
        logic        [23:0] w;
        logic        [23:0] h;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic               bf;
    } t_sl;

    typedef struct packed {
        logic        [24:0] ax;
        logic        [24:0] ay;
        logic               gx;
        logic               gy;
        logic               far;
        logic signed [24:0] px;
        logic signed [24:0] py;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic        [23:0] rad;
        logic        [23:0] w;
        logic        [23:0] h;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic               bf;
    } t_sc;

    typedef struct packed {
        logic        [49:0] sqx;
        logic        [49:0] sqy;
        logic        [49:0] r2sq;
        t_sc                k;
    } t_sq;

    typedef struct packed {
        logic        [24:0] ax;
        logic        [24:0] ay;
        logic               gx;
        logic               gy;
        logic               hit;
        logic               enclosed;
        logic        [1:0]  face;
        logic        [25:0] pen_in;
        logic signed [24:0] px;
        logic signed [24:0] py;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic        [23:0] rad;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic               bf;
    } t_sb;

    typedef struct packed {
        logic [43:0] rem_x;
        logic [43:0] rem_y;
        logic [14:0] qx;
        logic [14:0] qy;
        logic [29:0] root;
        logic [25:0] pen;
        t_sb         ctx;
    } t_dv;

    typedef struct packed {
        logic signed [31:0] lnxc;
        logic signed [31:0] lnys;
        logic signed [31:0] lnxs;
        logic signed [31:0] lnyc;
        logic signed [40:0] pxc;
        logic signed [40:0] pys;
        logic signed [40:0] pxs;
        logic signed [40:0] pyc;
        logic               hit;
        logic               bf;
        logic        [25:0] pen;
        logic signed [31:0] bx;
        logic signed [31:0] by;
    } t_sr;

    logic                en;
    logic [PIPE_LAT-1:0] r_vld;
    t_sa                 r_a [CORDIC_LAT];
    t_sa                 n_a0;
    logic signed [15:0]  c_cos, c_sin;
    t_sm                 r_m, n_m;
    t_sl                 r_l, n_l;
    t_sc                 r_c, n_c;
    t_sq                 r_q, n_q;
    t_sb                 r_d, n_d;
    logic [50:0]         r_d2, n_d2;
    t_sb                 r_b [SQRT_LAT];
    logic [SQRT_LAT-1:0] s_root;
    t_dv                 r_dv [DIV_LAT];
    t_dv                 n_dv [DIV_LAT];
    t_sr                 r_r, n_r;
    t_out                r_out, n_out;

    function automatic logic signed [15:0] clamp_norm(input logic signed [18:0] v);
        logic signed [15:0] o;
        if (v > 19'sd16384) begin
            o = 16'(NORM_ONE);
        end else if (v < -19'sd16384) begin
            o = -16'(NORM_ONE);
        end else begin
            o = 16'(v);
        end
        return o;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] o;
        if (v > 34'sd2147483647) begin
            o = 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            o = 32'sh80000000;
        end else begin
            o = 32'(v);
        end
        return o;
    endfunction

    assign en      = !(r_vld[PIPE_LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[PIPE_LAT-1];
    assign o_data  = r_out;

    always_comb begin
        n_a0.dx  = 33'(i_data.circle_x) - 33'(i_data.box_x);
        n_a0.dy  = 33'(i_data.circle_y) - 33'(i_data.box_y);
        n_a0.rad = i_data.circle_radius;
        n_a0.w   = i_data.box_width;
        n_a0.h   = i_data.box_height;
        n_a0.bx  = i_data.box_x;
        n_a0.by  = i_data.box_y;
        n_a0.bf  = i_data.box_first;
    end

    cobc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_data.box_angle),
        .o_cos   (c_cos),
        .o_sin   (c_sin)
    );

    // rotate offset into the box frame
    always_comb begin
        n_m.pxc = 49'(r_a[CORDIC_LAT-1].dx) * 49'(c_cos);
        n_m.pys = 49'(r_a[CORDIC_LAT-1].dy) * 49'(c_sin);
        n_m.pyc = 49'(r_a[CORDIC_LAT-1].dy) * 49'(c_cos);
        n_m.pxs = 49'(r_a[CORDIC_LAT-1].dx) * 49'(c_sin);
        n_m.c   = c_cos;
        n_m.s   = c_sin;
        n_m.rad = r_a[CORDIC_LAT-1].rad;
        n_m.w   = r_a[CORDIC_LAT-1].w;
        n_m.h   = r_a[CORDIC_LAT-1].h;
        n_m.bx  = r_a[CORDIC_LAT-1].bx;
        n_m.by  = r_a[CORDIC_LAT-1].by;
        n_m.bf  = r_a[CORDIC_LAT-1].bf;
    end

    always_comb begin
        n_l.lx  = 35'((r_m.pxc + r_m.pys + 49'sd4096) >>> 13);
        n_l.ly  = 35'((r_m.pyc - r_m.pxs + 49'sd4096) >>> 13);
        n_l.c   = r_m.c;
        n_l.s   = r_m.s;
        n_l.rad = r_m.rad;
        n_l.w   = r_m.w;
        n_l.h   = r_m.h;
        n_l.bx  = r_m.bx;
        n_l.by  = r_m.by;
        n_l.bf  = r_m.bf;
    end

    // clamp to the box, distance to the closest point
    always_comb begin
        logic signed [34:0] wl, hl, px, py, ddx, ddy, ax, ay;
        logic        [34:0] r2;
        wl = {11'b0, r_l.w};
        hl = {11'b0, r_l.h};
        r2 = {10'b0, r_l.rad, 1'b0};
        if (r_l.lx > wl) begin
            px = wl;
        end else if (r_l.lx < -wl) begin
            px = -wl;
        end else begin
            px = r_l.lx;
        end
        if (r_l.ly > hl) begin
            py = hl;
        end else if (r_l.ly < -hl) begin
            py = -hl;
        end else begin
            py = r_l.ly;
        end
        ddx = r_l.lx - px;
        ddy = r_l.ly - py;
        ax  = (ddx < 0) ? -ddx : ddx;
        ay  = (ddy < 0) ? -ddy : ddy;
        n_c.ax  = ax[24:0];
        n_c.ay  = ay[24:0];
        n_c.gx  = ddx > 0;
        n_c.gy  = ddy > 0;
        n_c.far = ($unsigned(ax) >= r2) || ($unsigned(ay) >= r2);
        n_c.px  = 25'(px);
        n_c.py  = 25'(py);
        n_c.c   = r_l.c;
        n_c.s   = r_l.s;
        n_c.rad = r_l.rad;
        n_c.w   = r_l.w;
        n_c.h   = r_l.h;
        n_c.bx  = r_l.bx;
        n_c.by  = r_l.by;
        n_c.bf  = r_l.bf;
    end

    always_comb begin
        n_q.sqx  = 50'(r_c.ax) * 50'(r_c.ax);
        n_q.sqy  = 50'(r_c.ay) * 50'(r_c.ay);
        n_q.r2sq = 50'({r_c.rad, 1'b0}) * 50'({r_c.rad, 1'b0});
        n_q.k    = r_c;
    end

    // hit test and nearest face for a centre inside the box
    always_comb begin
        logic signed [25:0] wz, hz, pxe, pye, dl, dr, db, dt, m;
        wz  = {2'b0, r_q.k.w};
        hz  = {2'b0, r_q.k.h};
        pxe = 26'(r_q.k.px);
        pye = 26'(r_q.k.py);
        dl  = pxe + wz;
        dr  = wz - pxe;
        db  = pye + hz;
        dt  = hz - pye;
        m   = dl;
        if (dr < m) begin
            m = dr;
        end
        if (db < m) begin
            m = db;
        end
        if (dt < m) begin
            m = dt;
        end
        if (m == dl) begin
            n_d.face = FACE_L;
        end else if (m == dr) begin
            n_d.face = FACE_R;
        end else if (m == db) begin
            n_d.face = FACE_B;
        end else begin
            n_d.face = FACE_T;
        end
        n_d2         = 51'(r_q.sqx) + 51'(r_q.sqy);
        n_d.hit      = !r_q.k.far && (n_d2 < 51'(r_q.r2sq));
        n_d.enclosed = (n_d2 == '0);
        n_d.pen_in   = 26'(({2'b0, r_q.k.rad, 1'b0} + {2'b0, m[24:0]} + 27'd1) >> 1);
        n_d.ax       = r_q.k.ax;
        n_d.ay       = r_q.k.ay;
        n_d.gx       = r_q.k.gx;
        n_d.gy       = r_q.k.gy;
        n_d.px       = r_q.k.px;
        n_d.py       = r_q.k.py;
        n_d.c        = r_q.k.c;
        n_d.s        = r_q.k.s;
        n_d.rad      = r_q.k.rad;
        n_d.bx       = r_q.k.bx;
        n_d.by       = r_q.k.by;
        n_d.bf       = r_q.k.bf;
    end

    cobc_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  ({1'b0, r_d2, 8'b0}),
        .o_root (s_root)
    );

    // normal magnitude by restoring division, one quotient bit per stage
    always_comb begin
        logic [43:0]        dsh;
        logic signed [31:0] po;
        int                 b;
        po = $signed({3'b0, r_b[SQRT_LAT-1].rad, 5'b0}) - $signed({2'b0, s_root})
           + 32'sd16;
        n_dv[0].rem_x = 44'({r_b[SQRT_LAT-1].ax, 18'b0}) + 44'(s_root[29:1]);
        n_dv[0].rem_y = 44'({r_b[SQRT_LAT-1].ay, 18'b0}) + 44'(s_root[29:1]);
        n_dv[0].qx    = '0;
        n_dv[0].qy    = '0;
        n_dv[0].root  = s_root;
        n_dv[0].pen   = r_b[SQRT_LAT-1].enclosed ? r_b[SQRT_LAT-1].pen_in
                                                 : 26'(po >>> 5);
        n_dv[0].ctx   = r_b[SQRT_LAT-1];
        for (int k = 1; k < DIV_LAT; k++) begin
            b   = DIV_LAT - 1 - k;
            dsh = 44'(r_dv[k-1].root) << b;
            n_dv[k] = r_dv[k-1];
            if (r_dv[k-1].rem_x >= dsh) begin
                n_dv[k].rem_x = r_dv[k-1].rem_x - dsh;
                n_dv[k].qx[b] = 1'b1;
            end
            if (r_dv[k-1].rem_y >= dsh) begin
                n_dv[k].rem_y = r_dv[k-1].rem_y - dsh;
                n_dv[k].qy[b] = 1'b1;
            end
        end
    end

    // local normal, then rotate normal and contact back to world
    always_comb begin
        logic signed [15:0] mx, my, lnx, lny;
        t_dv                d;
        d  = r_dv[DIV_LAT-1];
        mx = {1'b0, d.qx};
        my = {1'b0, d.qy};
        if (d.qx > 15'(NORM_ONE)) begin
            mx = 16'(NORM_ONE);
        end
        if (d.qy > 15'(NORM_ONE)) begin
            my = 16'(NORM_ONE);
        end
        if (d.ctx.enclosed) begin
            lnx = '0;
            lny = '0;
            case (d.ctx.face)
                FACE_L:  lnx = 16'(NORM_ONE);
                FACE_R:  lnx = -16'(NORM_ONE);
                FACE_B:  lny = 16'(NORM_ONE);
                default: lny = -16'(NORM_ONE);
            endcase
        end else begin
            lnx = d.ctx.gx ? -mx : mx;
            lny = d.ctx.gy ? -my : my;
        end
        n_r.lnxc = 32'(lnx) * 32'(d.ctx.c);
        n_r.lnys = 32'(lny) * 32'(d.ctx.s);
        n_r.lnxs = 32'(lnx) * 32'(d.ctx.s);
        n_r.lnyc = 32'(lny) * 32'(d.ctx.c);
        n_r.pxc  = 41'(d.ctx.px) * 41'(d.ctx.c);
        n_r.pys  = 41'(d.ctx.py) * 41'(d.ctx.s);
        n_r.pxs  = 41'(d.ctx.px) * 41'(d.ctx.s);
        n_r.pyc  = 41'(d.ctx.py) * 41'(d.ctx.c);
        n_r.hit  = d.ctx.hit;
        n_r.bf   = d.ctx.bf;
        n_r.pen  = d.pen;
        n_r.bx   = d.ctx.bx;
        n_r.by   = d.ctx.by;
    end

    always_comb begin
        logic signed [32:0] nsx, nsy;
        logic signed [41:0] csx, csy;
        logic signed [15:0] nx, ny;
        nsx = 33'(r_r.lnxc) - 33'(r_r.lnys) + 33'sd8192;
        nsy = 33'(r_r.lnxs) + 33'(r_r.lnyc) + 33'sd8192;
        csx = 42'(r_r.pxc) - 42'(r_r.pys) + 42'sd16384;
        csy = 42'(r_r.pxs) + 42'(r_r.pyc) + 42'sd16384;
        nx  = clamp_norm(19'(nsx >>> 14));
        ny  = clamp_norm(19'(nsy >>> 14));
        if (r_r.bf) begin
            nx = -nx;
            ny = -ny;
        end
        n_out = '0;
        if (r_r.hit) begin
            n_out.hit         = 1'b1;
            n_out.penetration = r_r.pen;
            n_out.normal_x    = nx;
            n_out.normal_y    = ny;
            n_out.contact_x   = sat32(34'(r_r.bx) + 34'(csx >>> 15));
            n_out.contact_y   = sat32(34'(r_r.by) + 34'(csy >>> 15));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a[0] <= n_a0;
            for (int i = 1; i < CORDIC_LAT; i++) begin
                r_a[i] <= r_a[i-1];
            end
            r_m  <= n_m;
            r_l  <= n_l;
            r_c  <= n_c;
            r_q  <= n_q;
            r_d  <= n_d;
            r_d2 <= n_d2;
            r_b[0] <= r_d;
            for (int i = 1; i < SQRT_LAT; i++) begin
                r_b[i] <= r_b[i-1];
            end
            for (int i = 0; i < DIV_LAT; i++) begin
                r_dv[i] <= n_dv[i];
            end
            r_r   <= n_r;
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

[tb/tb.sv]
// Testbench for the circle versus rotated box contact test: random and directed words, scoreboard.
`timescale 1ns / 1ps
`default_nettype none

module tb import cobc_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_data = '0;
    logic o_stall;
    logic o_valid;
    t_out o_data;

    t_in  pending_words[$];
    t_out contact_queue[$];
    int   error_count = 0;
    int   idle_cycles = 0;
    bit   stim_done = 1'b0;
    bit   quiet = 1'b0;
    bit   hold_off = 1'b0;
    bit   tx_taken = 1'b0;
    int   tx_gap = 0;
    int   rx_gap = 0;

    circle_vs_oriented_box_collision i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic void box_trig(input logic [15:0] ang, output longint co,
                                     output longint si);
        longint x, y, z, xs, ys, c, s, at;
        x = CORDIC_GAIN;
        y = 0;
        z = longint'(ang[13:0]) <<< 6;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            at = longint'(cordic_atan(i));
            if (z >= 0) begin
                x -= ys; y += xs; z -= at;
            end else begin
                x += ys; y -= xs; z += at;
            end
        end
        c = clip(round_shift(x, 16), -NORM_ONE, NORM_ONE);
        s = clip(round_shift(y, 16), -NORM_ONE, NORM_ONE);
        case (ang[15:14])
            2'd0: begin co = c;  si = s;  end
            2'd1: begin co = -s; si = c;  end
            2'd2: begin co = -c; si = -s; end
            default: begin co = s; si = -c; end
        endcase
    endfunction

    function automatic t_out predict_contact(t_in w);
        t_out r;
        longint c, s, dx, dy, lx, ly, px, py, ddx, ddy, ax, ay, rr, rr2, wd, ht;
        longint lnx, lny, lcx, lcy, pen, nx, ny, wx, wy, dd, mx, my;
        longint dl, dr, db, dt, m;
        longint unsigned d2;
        r = '0;
        box_trig(w.box_angle, c, s);
        rr = longint'(w.circle_radius);
        rr2 = 2 * rr;
        wd = longint'(w.box_width);
        ht = longint'(w.box_height);
        dx = longint'(w.circle_x) - longint'(w.box_x);
        dy = longint'(w.circle_y) - longint'(w.box_y);
        lx = round_shift(dx * c + dy * s, 13);
        ly = round_shift(dy * c - dx * s, 13);
        px = clip(lx, -wd, wd);
        py = clip(ly, -ht, ht);
        ddx = lx - px;
        ddy = ly - py;
        ax = ddx < 0 ? -ddx : ddx;
        ay = ddy < 0 ? -ddy : ddy;
        if (ax >= rr2 || ay >= rr2) return r;
        d2 = longint'(ax * ax) + longint'(ay * ay);
        if (d2 >= longint'(rr2 * rr2)) return r;
        if (d2 > 0) begin
            dd = int_sqrt(d2 << 8);
            mx = (ax * (64'sd1 <<< 18) + dd / 2) / dd;
            my = (ay * (64'sd1 <<< 18) + dd / 2) / dd;
            pen = (32 * rr - dd + 16) >>> 5;
            mx = mx > NORM_ONE ? NORM_ONE : mx;
            my = my > NORM_ONE ? NORM_ONE : my;
            lnx = ddx > 0 ? -mx : mx;
            lny = ddy > 0 ? -my : my;
            lcx = px;
            lcy = py;
        end else begin
            dl = lx + wd; dr = wd - lx; db = ly + ht; dt = ht - ly;
            m = dl;
            m = dr < m ? dr : m;
            m = db < m ? db : m;
            m = dt < m ? dt : m;
            lnx = 0; lny = 0;
            if (m == dl) lnx = NORM_ONE;
            else if (m == dr) lnx = -NORM_ONE;
            else if (m == db) lny = NORM_ONE;
            else lny = -NORM_ONE;
            pen = (rr2 + m + 1) >>> 1;
            lcx = lx;
            lcy = ly;
        end
        nx = clip(round_shift(lnx * c - lny * s, 14), -NORM_ONE, NORM_ONE);
        ny = clip(round_shift(lnx * s + lny * c, 14), -NORM_ONE, NORM_ONE);
        if (w.box_first) begin
            nx = -nx; ny = -ny;
        end
        wx = clip(longint'(w.box_x) + round_shift(lcx * c - lcy * s, 15),
                  -64'sd2147483648, 64'sd2147483647);
        wy = clip(longint'(w.box_y) + round_shift(lcx * s + lcy * c, 15),
                  -64'sd2147483648, 64'sd2147483647);
        r.hit = 1'b1;
        r.penetration = pen[25:0];
        r.normal_x = nx[15:0];
        r.normal_y = ny[15:0];
        r.contact_x = wx[31:0];
        r.contact_y = wy[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic t_in rand_word();
        t_in w;
        int sel;
        w.circle_x = $urandom;
        w.circle_y = $urandom;
        w.circle_radius = 24'($urandom);
        w.box_x = $urandom;
        w.box_y = $urandom;
        w.box_angle = 16'($urandom);
        w.box_width = 24'($urandom);
        w.box_height = 24'($urandom);
        w.box_first = 1'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 8) begin
            // near-contact geometry so most words exercise the hit path
            w.box_x = $signed($urandom) >>> $urandom_range(0, 12);
            w.box_y = $signed($urandom) >>> $urandom_range(0, 12);
            w.box_width = 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 10));
            w.box_height = 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 10));
            w.circle_radius = 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 10));
            w.circle_x = w.box_x + ($signed($urandom) >>> $urandom_range(6, 16));
            w.circle_y = w.box_y + ($signed($urandom) >>> $urandom_range(6, 16));
            if (sel == 0) w.box_width = '0;
            if (sel == 1) w.box_height = '0;
        end
        return w;
    endfunction

    function automatic t_in make_word(longint cx, longint cy, longint rad, longint bx,
                                      longint by, int ang, longint wd, longint ht, bit bf);
        t_in w;
        w.circle_x = 32'(cx); w.circle_y = 32'(cy); w.circle_radius = 24'(rad);
        w.box_x = 32'(bx); w.box_y = 32'(by); w.box_angle = 16'(ang);
        w.box_width = 24'(wd); w.box_height = 24'(ht); w.box_first = bf;
        return w;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || tx_taken) begin
            if (tx_taken) void'(pending_words.pop_front());
            tx_taken = 1'b0;
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_valid <= 1'b0;
            end else if (hold_off || pending_words.size() == 0) begin
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_data <= pending_words[0];
                if (!quiet && $urandom_range(0, 15) == 0) tx_gap <= $urandom_range(1, 8);
            end
        end
        if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            rx_gap <= $urandom_range(0, 7);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // input accept: predict; output accept: compare
    always @(posedge i_clk) begin
        t_out want;
        bit   moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                contact_queue.push_back(predict_contact(i_data));
                tx_taken = 1'b1;
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                if (contact_queue.size() == 0) begin
                    report_mismatch("unexpected word", 0, 0);
                end else begin
                    want = contact_queue.pop_front();
                    if (o_data.hit != want.hit)
                        report_mismatch("hit", o_data.hit, want.hit);
                    if (o_data.penetration != want.penetration)
                        report_mismatch("penetration", o_data.penetration, want.penetration);
                    if (o_data.normal_x != want.normal_x)
                        report_mismatch("normal_x", o_data.normal_x, want.normal_x);
                    if (o_data.normal_y != want.normal_y)
                        report_mismatch("normal_y", o_data.normal_y, want.normal_y);
                    if (o_data.contact_x != want.contact_x)
                        report_mismatch("contact_x", o_data.contact_x, want.contact_x);
                    if (o_data.contact_y != want.contact_y)
                        report_mismatch("contact_y", o_data.contact_y, want.contact_y);
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** circle_vs_oriented_box_collision: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        longint u;
        u = 64'sd65536;
        // directed: extremes, inside faces, ties, degenerate boxes, zero radius
        pending_words.push_back(make_word(0, 0, 0, 0, 0, 0, u, u, 0));
        pending_words.push_back(make_word(0, 0, u, 0, 0, 0, u, u, 0));
        pending_words.push_back(make_word(0, 0, u, 0, 0, 0, u, u, 1));
        pending_words.push_back(make_word(-u / 2, 0, u, 0, 0, 0, u, u, 0));
        pending_words.push_back(make_word(u / 2, 0, u, 0, 0, 0, u, u, 0));
        pending_words.push_back(make_word(0, -u / 2, u, 0, 0, 0, u, u, 0));
        pending_words.push_back(make_word(0, u / 2, u, 0, 0, 0, u, u, 0));
        pending_words.push_back(make_word(3 * u, 0, 4 * u, 0, 0, 16384, u, u, 0));
        pending_words.push_back(make_word(2 * u, 2 * u, 3 * u, 0, 0, 8192, u, u, 1));
        pending_words.push_back(make_word(u, 0, u, 0, 0, 32768, 0, 0, 0));
        pending_words.push_back(make_word(u, u, 2 * u, 0, 0, 49152, 0, u, 0));
        pending_words.push_back(make_word(u, u, 2 * u, 0, 0, 65535, u, 0, 1));
        pending_words.push_back(make_word(10 * u, 0, u, 0, 0, 0, u, u, 0));
        pending_words.push_back(make_word(32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF,
                                          32'h7FFF0000, 32'h7FFF0000, 0, 24'hFFFFFF,
                                          24'hFFFFFF, 0));
        pending_words.push_back(make_word(-64'sd2147483648, -64'sd2147483648, 24'hFFFFFF,
                                          -64'sd2147418112, -64'sd2147418112, 12345,
                                          24'hFFFFFF, 24'hFFFFFF, 1));
        pending_words.push_back(make_word(32'h7FFFFFFF, -64'sd2147483648, 24'hFFFFFF,
                                          -64'sd2147483648, 32'h7FFFFFFF, 40000,
                                          24'hFFFFFF, 24'hFFFFFF, 0));
        pending_words.push_back(make_word(0, 0, 24'hFFFFFF, 0, 0, 16384, 24'hFFFFFF,
                                          24'hFFFFFF, 1));
        pending_words.push_back(make_word(u + 5, 0, 10, 0, 0, 0, u, u, 0));
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 1700; i++) begin
            if (i == 800) begin
                wait (pending_words.size() == 0);
                hold_off = 1'b1;
                wait (contact_queue.size() == 0);
                hold_off = 1'b0;
            end
            if (i == 1400) quiet = 1'b1;
            pending_words.push_back(rand_word());
            if (pending_words.size() > 32) wait (pending_words.size() <= 16);
        end
        wait (pending_words.size() == 0);
        wait (contact_queue.size() == 0);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** circle_vs_oriented_box_collision: PASSED **");
        end else begin
            $display("** circle_vs_oriented_box_collision: FAILED **");
        end
        $finish;
    end
endmodule

`default_nettype wire
